### design/lmts_pkg.sv
`timescale 1ns / 1ps

package lmts_pkg;

    // Mode lengths in cycles and frame geometry in lines.
    localparam logic [11:0] HBLANK_LEN      = 12'd204;
    localparam logic [11:0] OAM_LEN         = 12'd80;
    localparam logic [11:0] ACTIVE_LEN      = 12'd172;
    localparam logic [11:0] VBLANK_LEN      = 12'd456;
    localparam logic [7:0]  LINES_PER_FRAME = 8'd154;
    localparam logic [7:0]  VISIBLE_LINES   = 8'd144;

    localparam int          ACC_W   = 24;
    localparam logic [23:0] ACC_MAX = 24'hFFFFFF;

    localparam logic [7:0] KEEP_MASK = 8'hfc;
    localparam logic [7:0] MODE_MASK = 8'h03;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_ACTIVE = 2'd3;

    // Bit positions in the status byte.
    localparam int BIT_COINC      = 2;
    localparam int BIT_INT_HBLANK = 3;
    localparam int BIT_INT_VBLANK = 4;
    localparam int BIT_INT_OAM    = 5;
    localparam int BIT_INT_LYC    = 6;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_WR_STATUS  = 2'd1,
        CMD_WR_COMPARE = 2'd2,
        CMD_NOP        = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] elapsed_cycles;
        logic [7:0]  write_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] line;
        logic [7:0] status;
        logic       vblank_irq;
        logic       stat_irq;
        logic       draw_line;
        logic       clear_screen;
    } t_out_item;

    typedef struct packed {
        logic [ACC_W-1:0] cycle_accum;
        logic [7:0]       lcd_status;
        logic [7:0]       line_counter;
        logic [7:0]       compare_line;
    } t_state;

endpackage

### design/lmts_step.sv
`timescale 1ns / 1ps

module lmts_step (
    input  lmts_pkg::t_state    i_state,
    input  lmts_pkg::t_in_item  i_item,
    output lmts_pkg::t_state    o_state,
    output lmts_pkg::t_out_item o_result
);

    logic [lmts_pkg::ACC_W:0]   w_sum;
    logic [lmts_pkg::ACC_W-1:0] w_acc;
    logic [11:0]                w_len;
    logic                       w_over;
    logic [8:0]                 w_inc;
    logic [7:0]                 w_new_line;
    logic [7:0]                 w_keep;
    logic                       w_vbl;
    logic                       w_stat;
    logic                       w_draw;
    logic                       w_clr;
    lmts_pkg::t_state           w_next;

    assign w_sum = {1'b0, i_state.cycle_accum}
                 + {{(lmts_pkg::ACC_W - 11){1'b0}}, i_item.elapsed_cycles};
    assign w_acc = w_sum[lmts_pkg::ACC_W] ? lmts_pkg::ACC_MAX : w_sum[lmts_pkg::ACC_W-1:0];

    always_comb begin
        case (i_state.lcd_status[1:0])
            lmts_pkg::MODE_HBLANK: w_len = lmts_pkg::HBLANK_LEN;
            lmts_pkg::MODE_OAM:    w_len = lmts_pkg::OAM_LEN;
            lmts_pkg::MODE_ACTIVE: w_len = lmts_pkg::ACTIVE_LEN;
            default:               w_len = lmts_pkg::VBLANK_LEN;
        endcase
    end

    assign w_over = w_acc > {{(lmts_pkg::ACC_W - 12){1'b0}}, w_len};

    // The line counter always stays below the frame length, so the modulo
    // reduces to a single wrap check.
    assign w_inc      = {1'b0, i_state.line_counter} + 9'd1;
    assign w_new_line = (w_inc == {1'b0, lmts_pkg::LINES_PER_FRAME}) ? 8'd0 : w_inc[7:0];
    assign w_keep     = i_state.lcd_status & lmts_pkg::KEEP_MASK;

    always_comb begin
        w_next = i_state;
        w_vbl  = 1'b0;
        w_stat = 1'b0;
        w_draw = 1'b0;
        w_clr  = 1'b0;
        unique case (lmts_pkg::t_cmd'(i_item.cmd))
            lmts_pkg::CMD_WR_STATUS:  w_next.lcd_status   = i_item.write_value;
            lmts_pkg::CMD_WR_COMPARE: w_next.compare_line = i_item.write_value;
            lmts_pkg::CMD_TICK: begin
                w_next.cycle_accum = w_acc;
                if (w_over) begin
                    w_next.cycle_accum = w_acc - {{(lmts_pkg::ACC_W - 12){1'b0}}, w_len};
                    case (i_state.lcd_status[1:0])
                        lmts_pkg::MODE_HBLANK: begin
                            w_next.line_counter = w_new_line;
                            if (w_new_line == lmts_pkg::VISIBLE_LINES) begin
                                w_vbl             = 1'b1;
                                w_next.lcd_status = w_keep | {6'd0, lmts_pkg::MODE_VBLANK};
                                w_stat            = i_state.lcd_status[lmts_pkg::BIT_INT_VBLANK];
                            end else begin
                                w_clr             = (w_new_line == 8'd0);
                                w_draw            = (w_new_line < lmts_pkg::VISIBLE_LINES);
                                w_next.lcd_status = w_keep | {6'd0, lmts_pkg::MODE_OAM};
                                w_stat            = i_state.lcd_status[lmts_pkg::BIT_INT_OAM];
                            end
                            // The compare interrupt fires when the stored
                            // coincidence bit agrees with the line match.
                            if (i_state.lcd_status[lmts_pkg::BIT_INT_LYC]
                                && (i_state.lcd_status[lmts_pkg::BIT_COINC]
                                    == (i_state.compare_line == w_new_line))) begin
                                w_stat = 1'b1;
                            end
                        end
                        lmts_pkg::MODE_OAM: begin
                            w_next.lcd_status = w_keep | {6'd0, lmts_pkg::MODE_ACTIVE};
                        end
                        lmts_pkg::MODE_ACTIVE: begin
                            w_next.lcd_status = w_keep | {6'd0, lmts_pkg::MODE_HBLANK};
                            w_stat = i_state.lcd_status[lmts_pkg::BIT_INT_HBLANK];
                        end
                        default: begin
                            w_next.lcd_status = w_keep | {6'd0, lmts_pkg::MODE_OAM};
                            w_stat = i_state.lcd_status[lmts_pkg::BIT_INT_OAM];
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_state               = w_next;
    assign o_result.line         = w_next.line_counter;
    assign o_result.status       = w_next.lcd_status;
    assign o_result.vblank_irq   = w_vbl;
    assign o_result.stat_irq     = w_stat;
    assign o_result.draw_line    = w_draw;
    assign o_result.clear_screen = w_clr;

endmodule

### design/lcd_mode_timing_sequencer_core.sv
`timescale 1ns / 1ps

// LCD line and mode timing sequencer.
// The input channel carries commands: a tick with a cycle count, a status
// byte write or a compare line write. Every input beat produces exactly one
// output beat with the line counter, the status byte and the interrupt,
// draw and clear pulses that the command caused.
// A beat accepted from the sender lands in the input register; the step
// logic then updates the timing state and loads the result register as soon
// as the result register is empty or its beat is being taken.
// Throughput is one beat per cycle while the receiver does not stall; the
// state update is a single add, compare and subtract between the two registers.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more beat; after that o_in_stall rises
// until the result is taken.
// Reset (synchronous, active low) empties both registers and clears the
// accumulator, status byte, line counter and compare line. The block is
// ready for input in the first cycle after reset.
module lcd_mode_timing_sequencer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lmts_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lmts_pkg::t_out_item o_out_data
);

    logic                r_in_vld;
    lmts_pkg::t_in_item  r_in;
    logic                r_out_vld;
    lmts_pkg::t_out_item r_out;
    lmts_pkg::t_state    r_st;
    lmts_pkg::t_state    n_st;
    lmts_pkg::t_out_item n_out;
    logic                w_adv;
    logic                w_in_acc;

    lmts_step u_step (
        .i_state  (r_st),
        .i_item   (r_in),
        .o_state  (n_st),
        .o_result (n_out)
    );

    assign w_adv    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign w_in_acc = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_in_vld && !w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= '0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_st      <= n_st;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // The registered line counter never reaches the frame length.
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.line_counter < lmts_pkg::LINES_PER_FRAME)
        else $error("line counter out of range");

    // Entering vertical blank happens exactly at the first invisible line.
    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.vblank_irq) |->
        (o_out_data.line == lmts_pkg::VISIBLE_LINES
         && o_out_data.status[1:0] == lmts_pkg::MODE_VBLANK
         && !o_out_data.draw_line))
        else $error("vblank pulse on wrong line or mode");

    // A clear request only comes with drawing line zero.
    a_clear_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.clear_screen) |->
        (o_out_data.draw_line && o_out_data.line == 8'd0))
        else $error("clear request without draw of line zero");

    // A stall toward the sender only happens with the input register full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled without backpressure");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lmts_pkg::*;

    localparam int DIR_N       = 24;
    localparam int RAND_ITEMS  = 560;
    localparam int CLOSE_ITEMS = 70;
    localparam int CYCLE_CAP   = 500000;

    typedef struct packed {
        t_in_item  beat;
        logic      known;
        t_out_item want;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    lcd_mode_timing_sequencer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the timing state.
    logic [23:0] accum_cnt   = '0;
    logic [7:0]  stat_reg    = '0;
    logic [7:0]  ly_cnt      = '0;
    logic [7:0]  lyc_reg     = '0;

    t_out_item   lcd_reports[$];
    int          mismatches  = 0;
    int          clk_count   = 0;
    bit          calm        = 1'b0;
    int          stall_pct   = 0;
    int          stall_left  = 0;
    t_dir_row    dir_rows [0:DIR_N-1];

    function automatic t_out_item step_lcd_timing(t_in_item b);
        t_out_item   r;
        logic [24:0] sum;
        logic [8:0]  ly_next;
        logic        hit;
        r = '0;
        case (t_cmd'(b.cmd))
            CMD_WR_STATUS: begin
                stat_reg = b.write_value;
            end
            CMD_WR_COMPARE: begin
                lyc_reg = b.write_value;
            end
            CMD_TICK: begin
                sum = {1'b0, accum_cnt} + b.elapsed_cycles;
                accum_cnt = sum[24] ? ACC_MAX : sum[23:0];
                case (stat_reg[1:0])
                    MODE_HBLANK: begin
                        if (accum_cnt > HBLANK_LEN) begin
                            accum_cnt = accum_cnt - HBLANK_LEN;
                            ly_next = ({1'b0, ly_cnt} + 9'd1) % LINES_PER_FRAME;
                            ly_cnt = ly_next[7:0];
                            if (ly_cnt == VISIBLE_LINES) begin
                                r.vblank_irq = 1'b1;
                                stat_reg[1:0] = MODE_VBLANK;
                                r.stat_irq = stat_reg[BIT_INT_VBLANK];
                            end else begin
                                r.clear_screen = (ly_cnt == 8'd0);
                                r.draw_line = (ly_cnt < VISIBLE_LINES);
                                stat_reg[1:0] = MODE_OAM;
                                r.stat_irq = stat_reg[BIT_INT_OAM];
                            end
                            // The coincidence bit is compared, never updated.
                            hit = (lyc_reg == ly_cnt);
                            if (stat_reg[BIT_INT_LYC] && (stat_reg[BIT_COINC] == hit))
                                r.stat_irq = 1'b1;
                        end
                    end
                    MODE_OAM: begin
                        if (accum_cnt > OAM_LEN) begin
                            accum_cnt = accum_cnt - OAM_LEN;
                            stat_reg[1:0] = MODE_ACTIVE;
                        end
                    end
                    MODE_ACTIVE: begin
                        if (accum_cnt > ACTIVE_LEN) begin
                            accum_cnt = accum_cnt - ACTIVE_LEN;
                            stat_reg[1:0] = MODE_HBLANK;
                            r.stat_irq = stat_reg[BIT_INT_HBLANK];
                        end
                    end
                    default: begin
                        if (accum_cnt > VBLANK_LEN) begin
                            accum_cnt = accum_cnt - VBLANK_LEN;
                            stat_reg[1:0] = MODE_OAM;
                            r.stat_irq = stat_reg[BIT_INT_OAM];
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
        r.line   = ly_cnt;
        r.status = stat_reg;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // Offers one beat and holds it until taken, then records its outcome.
    task automatic send_beat(input t_in_item b, input logic known, input t_out_item want);
        t_out_item pred;
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        pred = step_lcd_timing(b);
        lcd_reports.push_back(known ? want : pred);
    endtask

    always @(posedge i_clk) begin
        clk_count <= clk_count + 1;
        if (clk_count == CYCLE_CAP) begin
            $display("** lcd_mode_timing_sequencer_core: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (clk_count[5:0] == 6'd0) begin
            case ($urandom_range(0, 2))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                default: stall_pct <= 30;
            endcase
        end
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 13);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lcd_reports.size() == 0) begin
                flag_mismatch("output beat with nothing pending", 0, 1);
            end else begin
                want = lcd_reports.pop_front();
                if (o_out_data.line !== want.line)
                    flag_mismatch("line", want.line, o_out_data.line);
                if (o_out_data.status !== want.status)
                    flag_mismatch("status", want.status, o_out_data.status);
                if (o_out_data.vblank_irq !== want.vblank_irq)
                    flag_mismatch("vblank_irq", want.vblank_irq, o_out_data.vblank_irq);
                if (o_out_data.stat_irq !== want.stat_irq)
                    flag_mismatch("stat_irq", want.stat_irq, o_out_data.stat_irq);
                if (o_out_data.draw_line !== want.draw_line)
                    flag_mismatch("draw_line", want.draw_line, o_out_data.draw_line);
                if (o_out_data.clear_screen !== want.clear_screen)
                    flag_mismatch("clear_screen", want.clear_screen,
                                  o_out_data.clear_screen);
            end
        end
    end

    initial begin
        t_in_item b;
        int       gap_pct;
        int       pick;
        logic [7:0] wv;
        dir_rows = '{
            {CMD_NOP,        12'hFFF, 8'hFF, 1'b1, 8'd0, 8'h00, 4'h0},
            {CMD_TICK,       12'd0,   8'hAA, 1'b1, 8'd0, 8'h00, 4'h0},
            {CMD_TICK,       12'd204, 8'h55, 1'b1, 8'd0, 8'h00, 4'h0},
            {CMD_WR_COMPARE, 12'd0,   8'd1,  1'b1, 8'd0, 8'h00, 4'h0},
            {CMD_WR_STATUS,  12'hFFF, 8'h60, 1'b1, 8'd0, 8'h60, 4'h0},
            {CMD_TICK,       12'd1,   8'h00, 1'b0, 20'h0},
            {CMD_TICK,       12'hFFF, 8'h00, 1'b0, 20'h0},
            {CMD_TICK,       12'd0,   8'hFF, 1'b0, 20'h0},
            {CMD_WR_STATUS,  12'd0,   8'hFF, 1'b0, 20'h0},
            {CMD_TICK,       12'd0,   8'h00, 1'b0, 20'h0},
            {CMD_TICK,       12'd0,   8'h00, 1'b0, 20'h0},
            {CMD_WR_COMPARE, 12'd0,   8'hFF, 1'b0, 20'h0},
            {CMD_WR_STATUS,  12'd0,   8'h5D, 1'b0, 20'h0},
            {CMD_TICK,       12'd0,   8'h00, 1'b0, 20'h0},
            {CMD_WR_STATUS,  12'd0,   8'h00, 1'b0, 20'h0},
            {CMD_TICK,       12'd0,   8'h00, 1'b0, 20'h0},
            {CMD_NOP,        12'd0,   8'h00, 1'b0, 20'h0},
            {CMD_WR_COMPARE, 12'd0,   8'd4,  1'b0, 20'h0},
            {CMD_WR_STATUS,  12'd0,   8'h40, 1'b0, 20'h0},
            {CMD_TICK,       12'd0,   8'h00, 1'b0, 20'h0},
            {CMD_WR_STATUS,  12'd0,   8'h40, 1'b0, 20'h0},
            {CMD_TICK,       12'd0,   8'h00, 1'b0, 20'h0},
            {CMD_WR_STATUS,  12'd0,   8'h44, 1'b0, 20'h0},
            {CMD_TICK,       12'd0,   8'h00, 1'b0, 20'h0}
        };
        gap_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIR_N; n++)
            send_beat(dir_rows[n].beat, dir_rows[n].known, dir_rows[n].want);

        // Mostly ticks near the mode lengths, so the accumulator hovers around
        // the thresholds and lines actually advance.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0) begin
                pick = $urandom_range(0, 2);
                gap_pct = (pick == 0) ? 0 : (pick == 1) ? 12 : 35;
            end
            b.elapsed_cycles = $urandom_range(0, 4095);
            b.write_value    = $urandom_range(0, 255);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                b.cmd = CMD_TICK;
                if ($urandom_range(0, 99) < 85)
                    b.elapsed_cycles = $urandom_range(0, 260);
            end else if (pick < 82) begin
                b.cmd = CMD_WR_STATUS;
                wv = b.write_value;
                if ($urandom_range(0, 9) < 7)
                    wv[1:0] = stat_reg[1:0];
                b.write_value = wv;
            end else if (pick < 94) begin
                b.cmd = CMD_WR_COMPARE;
                if ($urandom_range(0, 1) == 0)
                    b.write_value = ly_cnt + 8'($urandom_range(0, 3));
            end else begin
                b.cmd = CMD_NOP;
            end
            send_beat(b, 1'b0, '0);
            if (n == RAND_ITEMS / 2) begin
                i_in_valid <= 1'b0;
                while (lcd_reports.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < gap_pct) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end

        // Closing stretch at full rate: large ticks push the accumulator far
        // above every mode length, so nearly every tick makes a transition.
        calm = 1'b1;
        for (int n = 0; n < CLOSE_ITEMS; n++) begin
            b.elapsed_cycles = $urandom_range(3800, 4095);
            b.write_value    = $urandom_range(0, 255);
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                b.cmd = CMD_TICK;
            end else if (pick < 94) begin
                b.cmd = CMD_WR_STATUS;
                wv = b.write_value;
                wv[1:0] = stat_reg[1:0];
                b.write_value = wv;
            end else if (pick < 98) begin
                b.cmd = CMD_WR_COMPARE;
                b.write_value = $urandom_range(0, 153);
            end else begin
                b.cmd = CMD_NOP;
            end
            send_beat(b, 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (lcd_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (lcd_reports.size() != 0)
            flag_mismatch("results still pending at end", 0, lcd_reports.size());
        if (mismatches == 0)
            $display("** lcd_mode_timing_sequencer_core: PASSED **");
        else
            $display("** lcd_mode_timing_sequencer_core: FAILED **");
        $finish;
    end

endmodule

### files.f
design/lmts_pkg.sv
design/lmts_step.sv
design/lcd_mode_timing_sequencer_core.sv
bench/tb_top.sv
